@@ src/fesg_pkg.sv @@
// ----------------------------------------------------------------------------
// fesg_pkg: shared types and constants
// Field widths, the job descriptor, the span record and the sequencer states.
// ----------------------------------------------------------------------------
package fesg_pkg;

    localparam int COORD_W  = 12;   // centre coordinate
    localparam int RAD_W    = 6;    // radius and row offset
    localparam int POS_W    = 14;   // signed output row / column
    localparam int S_DATA_W = 40;   // 36 payload bits padded to whole bytes
    localparam int M_DATA_W = 64;   // 62 payload bits padded to whole bytes

    localparam int SQ_W     = 12;   // r * r
    localparam int SQSQ_W   = 24;   // rx^2 * ry^2
    localparam int XS_W     = 8;    // signed search column
    localparam int XX_W     = 14;   // x * x for x up to 127
    localparam int MUL_W    = 26;   // shared multiplier product
    localparam int DSTEP_W  = 20;   // (2x - 1) * ry^2
    localparam int DYW_W    = 19;   // (2y - 1) * rx^2

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [RAD_W-1:0]   radius_x;
        logic [RAD_W-1:0]   radius_y;
        logic               one_row;    // zero vertical radius: diameter row only
    } job_t;

    typedef struct packed {
        logic [RAD_W-1:0] row_offset;
        logic [POS_W-1:0] top_row;      // two's complement
        logic [POS_W-1:0] bottom_row;   // two's complement
        logic [POS_W-1:0] left_col;     // two's complement
        logic [POS_W-1:0] right_col;    // two's complement
        logic             last;
    } span_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_HH,
        ST_MUL_WW,
        ST_MUL_HW,
        ST_EMIT0,
        ST_ROW_START,
        ST_SQ,
        ST_TH,
        ST_DH,
        ST_TEST,
        ST_EMIT
    } state_t;

endpackage

@@ src/fesg_front.sv @@
// ----------------------------------------------------------------------------
// fesg_front: input classifier
// Unpack an ellipse transfer, saturate the radii and flag single-row jobs.
// ----------------------------------------------------------------------------
module fesg_front #(
    parameter int MAX_RADIUS = 63
) (
    input  logic [fesg_pkg::S_DATA_W-1:0] s_tdata,
    output fesg_pkg::job_t                job
);
    import fesg_pkg::*;

    logic [RAD_W-1:0] rx_raw;
    logic [RAD_W-1:0] ry_raw;
    logic [RAD_W-1:0] rad_max;

    assign rad_max = RAD_W'(MAX_RADIUS);
    assign rx_raw  = s_tdata[2*COORD_W +: RAD_W];
    assign ry_raw  = s_tdata[2*COORD_W+RAD_W +: RAD_W];

    always_comb begin
        job.center_x = s_tdata[0 +: COORD_W];
        job.center_y = s_tdata[COORD_W +: COORD_W];
        job.radius_x = (rx_raw > rad_max) ? rad_max : rx_raw;
        job.radius_y = (ry_raw > rad_max) ? rad_max : ry_raw;
        job.one_row  = (job.radius_y == '0);
    end

endmodule

@@ src/fesg_queue.sv @@
// ----------------------------------------------------------------------------
// fesg_queue: job queue
// Two-entry FIFO of job descriptors between the classifier and the walker.
// ----------------------------------------------------------------------------
module fesg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fesg_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output fesg_pkg::job_t pop_data,
    output logic           not_empty
);
    import fesg_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/fesg_back.sv @@
// ----------------------------------------------------------------------------
// fesg_back: span walker
// Walk the rows of one ellipse with a shared multiplier and a slope-tracking
// half-width search, and hold each span in an output register.
// ----------------------------------------------------------------------------
module fesg_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  fesg_pkg::job_t job,
    input  logic           job_valid,
    output logic           job_pop,
    output fesg_pkg::span_t span,
    output logic           span_valid,
    input  logic           span_ready
);
    import fesg_pkg::*;

    state_t                    state_reg, state_next;
    logic [COORD_W-1:0]        cx_reg, cx_next;
    logic [COORD_W-1:0]        cy_reg, cy_next;
    logic [RAD_W-1:0]          rx_reg, rx_next;
    logic [RAD_W-1:0]          ry_reg, ry_next;
    logic                      one_row_reg, one_row_next;
    logic [SQ_W-1:0]           hh_reg, hh_next;
    logic [SQ_W-1:0]           ww_reg, ww_next;
    logic [SQSQ_W-1:0]         hhww_reg, hhww_next;
    logic [RAD_W-1:0]          x0_reg, x0_next;
    logic signed [RAD_W:0]     dx_reg, dx_next;
    logic signed [XS_W-1:0]    x_reg, x_next;
    logic [RAD_W-1:0]          y_reg, y_next;
    logic [SQSQ_W-1:0]         yyww_reg, yyww_next;
    logic [DYW_W-1:0]          dyw_reg, dyw_next;
    logic [XX_W-1:0]           xx_reg, xx_next;
    logic [MUL_W-1:0]          t_reg, t_next;
    logic [DSTEP_W-1:0]        d_reg, d_next;
    span_t                     out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;

    logic [XX_W-1:0]           mul_a;
    logic [SQ_W-1:0]           mul_b;
    logic [MUL_W-1:0]          mul_p;
    logic                      out_free;
    logic                      x_pos;
    logic [MUL_W:0]            lhs_sum;
    logic                      fits;
    logic                      search_done;
    logic [RAD_W-1:0]          x_fin;
    logic                      row_last;

    assign out_free    = !out_valid_reg || span_ready;
    assign x_pos       = !x_reg[XS_W-1] && (x_reg != '0);
    assign lhs_sum     = {1'b0, t_reg} + (MUL_W+1)'(yyww_reg);
    assign fits        = lhs_sum <= (MUL_W+1)'(hhww_reg);
    assign search_done = !x_pos || fits;
    assign x_fin       = x_pos ? x_reg[RAD_W-1:0] : '0;
    assign row_last    = (y_reg == ry_reg);
    assign job_pop     = (state_reg == ST_IDLE) && job_valid;
    assign span        = out_reg;
    assign span_valid  = out_valid_reg;

    // Shared multiplier: one product per cycle, always captured in a register.
    always_comb begin
        case (state_reg)
            ST_MUL_HH: begin
                mul_a = XX_W'(ry_reg);
                mul_b = SQ_W'(ry_reg);
            end
            ST_MUL_WW: begin
                mul_a = XX_W'(rx_reg);
                mul_b = SQ_W'(rx_reg);
            end
            ST_MUL_HW: begin
                mul_a = XX_W'(hh_reg);
                mul_b = ww_reg;
            end
            ST_SQ: begin
                mul_a = XX_W'(x_reg[XS_W-2:0]);
                mul_b = SQ_W'(x_reg[XS_W-2:0]);
            end
            ST_TH: begin
                mul_a = xx_reg;
                mul_b = hh_reg;
            end
            ST_DH: begin
                mul_a = XX_W'(x_reg[XS_W-2:0]);
                mul_b = hh_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (job_valid) state_next = ST_MUL_HH;
            ST_MUL_HH:    state_next = ST_MUL_WW;
            ST_MUL_WW:    state_next = ST_MUL_HW;
            ST_MUL_HW:    state_next = ST_EMIT0;
            ST_EMIT0: begin
                if (out_free) state_next = one_row_reg ? ST_IDLE : ST_ROW_START;
            end
            ST_ROW_START: state_next = ST_SQ;
            ST_SQ:        state_next = x_pos ? ST_TH : ST_TEST;
            ST_TH:        state_next = ST_DH;
            ST_DH:        state_next = ST_TEST;
            ST_TEST:      if (search_done) state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) state_next = row_last ? ST_IDLE : ST_ROW_START;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        one_row_next   = one_row_reg;
        hh_next        = hh_reg;
        ww_next        = ww_reg;
        hhww_next      = hhww_reg;
        x0_next        = x0_reg;
        dx_next        = dx_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        yyww_next      = yyww_reg;
        dyw_next       = dyw_reg;
        xx_next        = xx_reg;
        t_next         = t_reg;
        d_next         = d_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !span_ready;

        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    cx_next      = job.center_x;
                    cy_next      = job.center_y;
                    rx_next      = job.radius_x;
                    ry_next      = job.radius_y;
                    one_row_next = job.one_row;
                end
            end
            ST_MUL_HH: hh_next   = mul_p[SQ_W-1:0];
            ST_MUL_WW: ww_next   = mul_p[SQ_W-1:0];
            ST_MUL_HW: hhww_next = mul_p[SQSQ_W-1:0];
            ST_EMIT0: begin
                if (out_free) begin
                    out_next.row_offset = '0;
                    out_next.top_row    = POS_W'(cy_reg);
                    out_next.bottom_row = POS_W'(cy_reg);
                    out_next.left_col   = POS_W'(cx_reg) - POS_W'(rx_reg);
                    out_next.right_col  = POS_W'(cx_reg) + POS_W'(rx_reg);
                    out_next.last       = one_row_reg;
                    out_valid_next      = 1'b1;
                    x0_next             = rx_reg;
                    dx_next             = '0;
                    y_next              = RAD_W'(1);
                    yyww_next           = '0;
                    dyw_next            = DYW_W'(ww_reg);
                end
            end
            ST_ROW_START: begin
                // Start one beyond the previous slope guess; advance y*y*rx*rx.
                x_next    = {2'b00, x0_reg} + XS_W'(1) - {dx_reg[RAD_W], dx_reg};
                yyww_next = yyww_reg + SQSQ_W'(dyw_reg);
                dyw_next  = dyw_reg + DYW_W'({ww_reg, 1'b0});
            end
            ST_SQ: xx_next = mul_p[XX_W-1:0];
            ST_TH: t_next  = mul_p;
            ST_DH: d_next  = DSTEP_W'({mul_p, 1'b0}) - DSTEP_W'(hh_reg);
            ST_TEST: begin
                if (search_done) begin
                    x0_next = x_fin;
                    dx_next = {1'b0, x0_reg} - {1'b0, x_fin};
                end else begin
                    // Step x down: x^2 drops by 2x-1, and that step by 2.
                    x_next = x_reg - XS_W'(1);
                    t_next = t_reg - MUL_W'(d_reg);
                    d_next = d_reg - DSTEP_W'({hh_reg, 1'b0});
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_next.row_offset = y_reg;
                    out_next.top_row    = POS_W'(cy_reg) - POS_W'(y_reg);
                    out_next.bottom_row = POS_W'(cy_reg) + POS_W'(y_reg);
                    out_next.left_col   = POS_W'(cx_reg) - POS_W'(x0_reg);
                    out_next.right_col  = POS_W'(cx_reg) + POS_W'(x0_reg);
                    out_next.last       = row_last;
                    out_valid_next      = 1'b1;
                    y_next              = y_reg + RAD_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        one_row_reg <= one_row_next;
        hh_reg      <= hh_next;
        ww_reg      <= ww_next;
        hhww_reg    <= hhww_next;
        x0_reg      <= x0_next;
        dx_reg      <= dx_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        yyww_reg    <= yyww_next;
        dyw_reg     <= dyw_next;
        xx_reg      <= xx_next;
        t_reg       <= t_next;
        d_reg       <= d_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    // A half width that passes the ellipse test never exceeds the horizontal radius.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TEST && x_pos && fits) |-> (x_reg <= $signed({2'b00, rx_reg})))
        else $error("fesg_back: half width beyond radius");

    // A span handed to the output register is offered on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT || state_reg == ST_EMIT0) && out_free) |=> out_valid_reg)
        else $error("fesg_back: emitted span not presented");

    // Row walking only happens for ellipses with a vertical radius.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROW_START) |-> (hh_reg != '0 && !one_row_reg))
        else $error("fesg_back: row walk on a single-row ellipse");

    // A new job is taken only after the previous one has issued its last span.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (job_pop && out_valid_reg) |-> out_reg.last)
        else $error("fesg_back: job taken before previous ellipse finished");
`endif

endmodule

@@ src/filled_ellipse_span_generator_core.sv @@
// ----------------------------------------------------------------------------
// filled_ellipse_span_generator_core: filled ellipse span generator
// Turn an ellipse (integer centre, two radii) into the horizontal spans that
// fill it: the diameter row first, then one mirrored span pair per row offset.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Transfer                                | Per item
//  s_*      | in        | one ellipse: centre and radii           | 1
//  m_*      | out       | one span pair (tlast on the final pair) | radius_y + 1
//
//  Schedule: the walker squares the radii and forms their product (MUL_HH,
//  MUL_WW, MUL_HW), emits the diameter row (EMIT0), then per row offset runs
//  ROW_START, SQ, TH, DH, TEST and EMIT (SQ goes straight to TEST when the
//  search starts at or below column zero), repeating TEST for each half-width
//  decrement; the shared multiplier and the one-step-a-cycle search loop set the pace.
//  Reset: aresetn is synchronous, active low; it empties the job queue and
//  drops any span held on the output.
//  Stalls: the two-entry job queue lets s_* accept up to two ellipses while the
//  walker is busy; a stalled m_* holds the walker in its emit step.
// ----------------------------------------------------------------------------
module filled_ellipse_span_generator_core #(
    parameter int MAX_RADIUS = 63
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [11:0] center_x, [23:12] center_y, [29:24] radius_x, [35:30] radius_y
    input  logic [fesg_pkg::S_DATA_W-1:0] s_tdata,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [5:0] row_offset, [19:6] top_row, [33:20] bottom_row,
    // [47:34] left_col, [61:48] right_col
    output logic [fesg_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import fesg_pkg::*;

    job_t  front_job;
    job_t  queue_job;
    logic  queue_full;
    logic  queue_valid;
    logic  queue_pop;
    logic  push;
    span_t span;

    // Accept an ellipse whenever the job queue has room.
    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    fesg_front #(
        .MAX_RADIUS(MAX_RADIUS)
    ) u_front (
        .s_tdata (s_tdata),
        .job     (front_job)
    );

    fesg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_job),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (queue_job),
        .not_empty (queue_valid)
    );

    fesg_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job        (queue_job),
        .job_valid  (queue_valid),
        .job_pop    (queue_pop),
        .span       (span),
        .span_valid (m_tvalid),
        .span_ready (m_tready)
    );

    // Pack the span fields, lowest first, zero padded to whole bytes.
    assign m_tdata = {2'b00, span.right_col, span.left_col, span.bottom_row,
                      span.top_row, span.row_offset};
    assign m_tlast = span.last;

endmodule
